FILE: sv/cbpe_pkg.sv
package cbpe_pkg;

    // Register file geometry.
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 12;
    localparam int IDX_W    = 3;

    // Internal parameter format: unsigned Q0.16 with 1.0 representable.
    localparam int TQ_FRAC = 16;
    localparam int TQ_W    = TQ_FRAC + 1;

    // Power-basis coefficient width (covers 3*(p0 - 2*p1 + p2) and p3 - 3*p2 + 3*p1 - p0).
    localparam int CF_W = 17;

    // Horner partial results: h1 in Q.16, h2 in Q.32, final sum in Q.48.
    localparam int H1_W    = 33;
    localparam int H2_W    = 49;
    localparam int LO_W    = 24;
    localparam int HI_W    = H2_W - LO_W;
    localparam int SUM_FRAC = 3 * TQ_FRAC;
    localparam int SUM_W   = 64;

    // Output coordinate format.
    localparam int OUT_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_P0_X,
        REG_P0_Y,
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y
    } t_reg_idx;

    typedef logic signed [REG_W-1:0] t_reg;
    typedef logic signed [CF_W-1:0]  t_cf;
    typedef logic [TQ_W-1:0]         t_tq;
    typedef logic signed [OUT_W-1:0] t_point;

    // Coefficients of the curve in power form: c0 + c1*s + c2*s^2 + c3*s^3.
    typedef struct packed {
        t_cf c0;
        t_cf c1;
        t_cf c2;
        t_cf c3;
    } t_coef;

    // Values the control points take after reset, in register index order.
    localparam t_reg CFG_RESET [NUM_REGS] = '{
        12'sd150, 12'sd100, 12'sd200, 12'sd200,
        12'sd300, 12'sd300, 12'sd350, 12'sd400
    };

    // Convert four control points of one axis into power-basis coefficients.
    function automatic t_coef coef(input t_reg p0, input t_reg p1,
                                   input t_reg p2, input t_reg p3);
        t_cf   a0;
        t_cf   a1;
        t_cf   a2;
        t_cf   a3;
        t_coef c;
        a0 = CF_W'(p0);
        a1 = CF_W'(p1);
        a2 = CF_W'(p2);
        a3 = CF_W'(p3);
        c.c0 = a0;
        c.c1 = CF_W'(3 * (a1 - a0));
        c.c2 = CF_W'(3 * (a0 - (a1 <<< 1) + a2));
        c.c3 = CF_W'(a3 - a0 + 3 * (a1 - a2));
        return c;
    endfunction

endpackage

FILE: sv/cbpe_axis.sv
module cbpe_axis #(
    parameter int OUT_FRAC_BITS = 4
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  cbpe_pkg::t_tq   i_tq,
    input  cbpe_pkg::t_coef i_coef,
    output cbpe_pkg::t_point o_point
);
    import cbpe_pkg::*;

    localparam int SH    = SUM_FRAC - OUT_FRAC_BITS;
    // Wide enough for the rounded sum and for both saturation limits.
    localparam int Q_W   = (REG_W + OUT_FRAC_BITS + 2 > OUT_W + 1) ?
                           REG_W + OUT_FRAC_BITS + 2 : OUT_W + 1;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'sd1) <<< (SH - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    // Stage 2: h1 = c3*t + c2 (Q.16).
    logic signed [H1_W+1:0]  m1;
    logic signed [H1_W-1:0]  r_h1;
    t_tq                     r_tq2;

    assign m1 = i_coef.c3 * $signed({1'b0, i_tq});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1  <= H1_W'(m1) + (H1_W'(i_coef.c2) <<< TQ_FRAC);
            r_tq2 <= i_tq;
        end
    end

    // Stage 3: h2 = h1*t + c1 (Q.32).
    logic signed [H1_W+TQ_W:0] m2;
    logic signed [H2_W-1:0]    r_h2;
    t_tq                       r_tq3;

    assign m2 = r_h1 * $signed({1'b0, r_tq2});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h2  <= H2_W'(m2) + (H2_W'(i_coef.c1) <<< (2 * TQ_FRAC));
            r_tq3 <= r_tq2;
        end
    end

    // Stage 4: h2*t split into two narrow partial products.
    logic [LO_W-1:0]               h2_lo;
    logic signed [HI_W-1:0]        h2_hi;
    logic [LO_W+TQ_W-1:0]          r_mlo;
    logic signed [HI_W+TQ_W:0]     r_mhi;

    assign h2_lo = r_h2[LO_W-1:0];
    assign h2_hi = r_h2[H2_W-1:LO_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mlo <= h2_lo * r_tq3;
            r_mhi <= h2_hi * $signed({1'b0, r_tq3});
        end
    end

    // Stage 5: add c0 (Q.48), round half up and drop fraction bits.
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_sh;
    logic signed [Q_W-1:0]   r_q;

    assign sum = (SUM_W'(r_mhi) <<< LO_W) + $signed(SUM_W'(r_mlo))
               + (SUM_W'(i_coef.c0) <<< SUM_FRAC) + RND;
    assign sum_sh = sum >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= sum_sh[Q_W-1:0];
        end
    end

    // Stage 6: saturate to the output range.
    t_point r_point;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_q > Q_MAX) begin
                r_point <= t_point'(Q_MAX);
            end else if (r_q < Q_MIN) begin
                r_point <= t_point'(Q_MIN);
            end else begin
                r_point <= r_q[OUT_W-1:0];
            end
        end
    end

    assign o_point = r_point;

endmodule

FILE: sv/cubic_bezier_point_evaluator.sv
// An accepted input transaction passes through the six registered stages before its result reaches the outputs.
// Throughput: one transaction per cycle; the six-stage multiply pipeline advances as a whole
// and holds only while a finished result waits on a stalled output.
// Reset (synchronous, active low) clears all valid bits and loads the default control points.
// Input is stalled while reset is asserted.
module cubic_bezier_point_evaluator #(
    parameter int T_FRAC_BITS   = 16,
    parameter int OUT_FRAC_BITS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [T_FRAC_BITS:0]      i_param_t,
    output logic                      o_valid,
    input  logic                      i_stall,
    output cbpe_pkg::t_point          o_point_x,
    output cbpe_pkg::t_point          o_point_y,
    input  logic                      i_cfg_we,
    input  cbpe_pkg::t_reg_idx        i_cfg_idx,
    input  cbpe_pkg::t_reg            i_cfg_data
);
    import cbpe_pkg::*;

    localparam int NSTG = 6;
    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

    // Pipeline control: everything moves unless the output holds a stalled result.
    logic            en;
    logic            in_acc;
    logic [NSTG-1:0] r_vld;

    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en || !i_rst_n;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], in_acc};
        end
    end

    // Control point registers.
    t_reg r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Power-basis coefficients, refreshed every cycle from the control points.
    t_coef r_coef_x;
    t_coef r_coef_y;

    always_ff @(posedge i_clk) begin
        r_coef_x <= coef(r_cfg[REG_P0_X], r_cfg[REG_P1_X], r_cfg[REG_P2_X], r_cfg[REG_P3_X]);
        r_coef_y <= coef(r_cfg[REG_P0_Y], r_cfg[REG_P1_Y], r_cfg[REG_P2_Y], r_cfg[REG_P3_Y]);
    end

    // Stage 1: clamp the parameter to 1.0 and convert it to Q0.16.
    logic [T_FRAC_BITS:0] t_clamp;
    t_tq                  n_tq;
    t_tq                  r_tq;

    assign t_clamp = (i_param_t > T_ONE) ? T_ONE : i_param_t;

    generate
        if (T_FRAC_BITS <= TQ_FRAC) begin : g_tq_shl
            assign n_tq = TQ_W'(t_clamp) << (TQ_FRAC - T_FRAC_BITS);
        end else begin : g_tq_rnd
            localparam int SHR = T_FRAC_BITS - TQ_FRAC;
            localparam logic [T_FRAC_BITS:0] HALF = (T_FRAC_BITS + 1)'(1) << (SHR - 1);
            logic [T_FRAC_BITS:0] t_rnd;
            assign t_rnd = (t_clamp + HALF) >> SHR;
            assign n_tq  = t_rnd[TQ_W-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tq <= n_tq;
        end
    end

    // Stages 2 to 6, one datapath per axis.
    cbpe_axis #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_axis_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_tq   (r_tq),
        .i_coef (r_coef_x),
        .o_point(o_point_x)
    );

    cbpe_axis #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_axis_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_tq   (r_tq),
        .i_coef (r_coef_y),
        .o_point(o_point_y)
    );

endmodule
